[rtl/core/assert_macros.svh]
// assertion macros shared by the masked region statistics rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define MRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent in the cycle after the antecedent
`define MRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/mrs_pkg.sv]
// constants, types and helpers for the masked region statistics block
// no dependencies; used by every module of the block but mrs_ram
package mrs_pkg;

  // frame geometry and gray range
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int GRAY_LEVELS = 256;
  localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = $clog2(MAX_DIM) + 1;
  localparam int BIN_W  = $clog2(GRAY_LEVELS);

  // fixed field widths
  localparam int GRAY_W = 8;
  localparam int REG_W  = 13;
  localparam int AREA_W = 25;
  localparam int SUM_W  = 35;
  localparam int EDGE_W = 26;
  localparam int GSUM_W = 32;

  localparam int RES_W       = AREA_W + 2 * SUM_W + EDGE_W + GSUM_W + 3 * GRAY_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(640);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(480);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // clamped frame size seen by the datapath
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } frame_size_t;

  // pixel held in the read-modify-write stage
  typedef struct packed {
    logic              valid;
    logic              frame_end;
    logic              mask;
    logic [GRAY_W-1:0] gray;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } stage_t;

  // one frame result, first field in the highest bits
  typedef struct packed {
    logic [GRAY_W-1:0] modal_gray;
    logic [GRAY_W-1:0] gray_max;
    logic [GRAY_W-1:0] gray_min;
    logic [GSUM_W-1:0] gray_total;
    logic [EDGE_W-1:0] edge_count;
    logic [SUM_W-1:0]  row_sum;
    logic [SUM_W-1:0]  column_sum;
    logic [AREA_W-1:0] area;
  } result_t;

  // histogram bin of a gray level, saturating at the last bin
  function automatic logic [BIN_W-1:0] gray_to_bin(input logic [GRAY_W-1:0] g);
    logic [BIN_W-1:0] b;
    if (32'(g) >= 32'(GRAY_LEVELS)) begin
      b = BIN_W'(GRAY_LEVELS - 1);
    end else begin
      b = BIN_W'(g);
    end
    return b;
  endfunction

endpackage

[rtl/core/mrs_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mrs_cfg.sv]
// apb-style configuration registers for frame width and height, with clamping
// depends on mrs_pkg
module mrs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mrs_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [mrs_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [mrs_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output mrs_pkg::frame_size_t          size
);

  logic [mrs_pkg::REG_W-1:0] width_r, width_nxt;
  logic [mrs_pkg::REG_W-1:0] height_r, height_nxt;
  logic                      wr;
  mrs_pkg::cfg_reg_t         sel;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign sel = mrs_pkg::cfg_reg_t'(cfg_paddr[2]);

  // register write decode
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr) begin
      case (sel)
        mrs_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_pwdata[mrs_pkg::REG_W-1:0];
        mrs_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_pwdata[mrs_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mrs_pkg::WIDTH_RST;
      height_r <= mrs_pkg::HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // read mux
  always_comb begin
    case (sel)
      mrs_pkg::REG_IMAGE_WIDTH:  cfg_prdata = mrs_pkg::CFG_DW'(width_r);
      mrs_pkg::REG_IMAGE_HEIGHT: cfg_prdata = mrs_pkg::CFG_DW'(height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) begin
      size.width = mrs_pkg::SIZE_W'(1);
    end else if (32'(width_r) > 32'(mrs_pkg::MAX_WIDTH)) begin
      size.width = mrs_pkg::SIZE_W'(mrs_pkg::MAX_WIDTH);
    end else begin
      size.width = mrs_pkg::SIZE_W'(width_r);
    end
    if (height_r == '0) begin
      size.height = mrs_pkg::SIZE_W'(1);
    end else if (32'(height_r) > 32'(mrs_pkg::MAX_HEIGHT)) begin
      size.height = mrs_pkg::SIZE_W'(mrs_pkg::MAX_HEIGHT);
    end else begin
      size.height = mrs_pkg::SIZE_W'(height_r);
    end
  end

endmodule

[rtl/core/mrs_scan.sv]
// raster position tracking, row-above mask memory and perimeter edge detection
// depends on mrs_pkg, mrs_ram and assert_macros.svh
`include "assert_macros.svh"
module mrs_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mrs_pkg::GRAY_W-1:0]  gray,
  input  logic                        mask,
  input  mrs_pkg::frame_size_t        size,
  input  logic                        adv,
  output logic                        accept,
  output mrs_pkg::stage_t             st,
  output logic [1:0]                  edge_inc
);

  logic [mrs_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [mrs_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [mrs_pkg::SIZE_W-1:0] col_p1, row_p1;
  logic                       row_end, frame_end;
  mrs_pkg::stage_t            st_r, st_nxt;
  logic                       left_r, left_nxt;
  logic                       clr_busy_r, clr_busy_nxt;
  logic [mrs_pkg::COL_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                       fwd_v_r, fwd_v_nxt;
  logic [mrs_pkg::COL_W-1:0]  fwd_col_r, fwd_col_nxt;
  logic                       fwd_m_r, fwd_m_nxt;
  logic                       done;
  logic                       ram_we;
  logic [mrs_pkg::COL_W-1:0]  ram_waddr;
  logic                       ram_wdata;
  logic                       ram_rdata;
  logic                       above;

  // handshake: no pixels during the clearing pass or while the stage is stuck
  assign in_tready = !clr_busy_r && (!st_r.valid || adv);
  assign accept    = in_tvalid && in_tready;
  assign done      = st_r.valid && adv;

  // position of the incoming pixel against the frame size
  assign col_p1    = mrs_pkg::SIZE_W'(col_r) + mrs_pkg::SIZE_W'(1);
  assign row_p1    = mrs_pkg::SIZE_W'(row_r) + mrs_pkg::SIZE_W'(1);
  assign row_end   = col_p1 >= size.width;
  assign frame_end = row_end && (row_p1 >= size.height);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // stage register
  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      st_nxt.valid     = 1'b1;
      st_nxt.frame_end = frame_end;
      st_nxt.mask      = mask;
      st_nxt.gray      = gray;
      st_nxt.col       = col_r;
      st_nxt.row       = row_r;
    end else if (done) begin
      st_nxt.valid = 1'b0;
    end
  end

  // left neighbour mask, cleared at frame end
  always_comb begin
    left_nxt = left_r;
    if (done) begin
      left_nxt = st_r.frame_end ? 1'b0 : st_r.mask;
    end
  end

  // clearing pass of the row memory after reset
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == mrs_pkg::COL_W'(mrs_pkg::MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // forward the write that lands on the same edge as a read
  always_comb begin
    fwd_v_nxt   = fwd_v_r;
    fwd_col_nxt = fwd_col_r;
    fwd_m_nxt   = fwd_m_r;
    if (accept) begin
      fwd_v_nxt   = done;
      fwd_col_nxt = st_r.col;
      fwd_m_nxt   = st_r.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      st_r.valid <= 1'b0;
      left_r     <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      fwd_v_r    <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      st_r       <= st_nxt;
      left_r     <= left_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      fwd_v_r    <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_col_r <= fwd_col_nxt;
    fwd_m_r   <= fwd_m_nxt;
  end

  // row-above mask memory
  assign ram_we    = clr_busy_r || done;
  assign ram_waddr = clr_busy_r ? clr_addr_r : st_r.col;
  assign ram_wdata = clr_busy_r ? 1'b0 : st_r.mask;

  mrs_ram #(
    .WIDTH (1),
    .DEPTH (mrs_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // perimeter transitions of the pixel in the stage
  assign above = (fwd_v_r && (fwd_col_r == st_r.col)) ? fwd_m_r : ram_rdata;

  always_comb begin
    edge_inc = 2'd0;
    if (st_r.valid) begin
      edge_inc = {1'b0, (st_r.col != '0) && (left_r != st_r.mask)}
               + {1'b0, (st_r.row != '0) && (above != st_r.mask)};
    end
  end

  assign st = st_r;

  `MRS_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clr_busy_r, !in_tready)
  `MRS_ASSERT_NXT(a_row_wraps_col, clk, rst_n, accept && row_end, col_r == '0)

endmodule

[rtl/core/mrs_accum.sv]
// frame statistics, histogram memory with modal tracking, and result register
// depends on mrs_pkg, mrs_ram and assert_macros.svh
`include "assert_macros.svh"
module mrs_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [mrs_pkg::GRAY_W-1:0]      rd_gray,
  input  mrs_pkg::stage_t                 st,
  input  logic [1:0]                      edge_inc,
  output logic                            adv,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  localparam int HL = mrs_pkg::GRAY_LEVELS;

  logic [mrs_pkg::AREA_W-1:0] count_r, count_nxt, count_upd;
  logic [mrs_pkg::SUM_W-1:0]  xsum_r, xsum_nxt, xsum_upd;
  logic [mrs_pkg::SUM_W-1:0]  ysum_r, ysum_nxt, ysum_upd;
  logic [mrs_pkg::EDGE_W-1:0] perim_r, perim_nxt, perim_upd;
  logic [mrs_pkg::GSUM_W-1:0] gsum_r, gsum_nxt, gsum_upd;
  logic [mrs_pkg::GRAY_W-1:0] min_r, min_nxt, min_upd;
  logic [mrs_pkg::GRAY_W-1:0] max_r, max_nxt, max_upd;
  logic [mrs_pkg::BIN_W-1:0]  best_bin_r, best_bin_nxt, best_bin_upd;
  logic [mrs_pkg::AREA_W-1:0] best_cnt_r, best_cnt_nxt, best_cnt_upd;
  logic [HL-1:0]              hvalid_r, hvalid_nxt;
  logic                       hfwd_v_r, hfwd_v_nxt;
  logic [mrs_pkg::BIN_W-1:0]  hfwd_bin_r, hfwd_bin_nxt;
  logic [mrs_pkg::AREA_W-1:0] hfwd_cnt_r, hfwd_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_empty_r, out_empty_nxt;
  mrs_pkg::result_t           res_r, res_nxt;
  logic [mrs_pkg::BIN_W-1:0]  bin;
  logic [mrs_pkg::AREA_W-1:0] ram_rdata, cnt_old, cnt_new;
  logic                       done, empty;

  // the stage holds a frame end only while an untaken result sits in the output
  assign adv  = !(st.valid && st.frame_end && out_valid_r && !out_tready);
  assign done = st.valid && adv;
  assign bin  = mrs_pkg::gray_to_bin(st.gray);

  // histogram memory: read on accept, write back from the stage
  mrs_ram #(
    .WIDTH (mrs_pkg::AREA_W),
    .DEPTH (HL)
  ) u_hist_ram (
    .clk   (clk),
    .we    (done && st.mask),
    .waddr (bin),
    .wdata (cnt_new),
    .re    (rd_en),
    .raddr (mrs_pkg::gray_to_bin(rd_gray)),
    .rdata (ram_rdata)
  );

  // bin count with forwarding; bins not written this frame read as zero
  always_comb begin
    if (hfwd_v_r && (hfwd_bin_r == bin)) begin
      cnt_old = hfwd_cnt_r;
    end else if (hvalid_r[bin]) begin
      cnt_old = ram_rdata;
    end else begin
      cnt_old = '0;
    end
    cnt_new = cnt_old + 1'b1;
  end

  // statistics including the pixel in the stage
  always_comb begin
    count_upd    = count_r;
    xsum_upd     = xsum_r;
    ysum_upd     = ysum_r;
    gsum_upd     = gsum_r;
    min_upd      = min_r;
    max_upd      = max_r;
    best_bin_upd = best_bin_r;
    best_cnt_upd = best_cnt_r;
    perim_upd    = perim_r + mrs_pkg::EDGE_W'(edge_inc);
    if (st.mask) begin
      count_upd = count_r + 1'b1;
      xsum_upd  = xsum_r + mrs_pkg::SUM_W'(st.col);
      ysum_upd  = ysum_r + mrs_pkg::SUM_W'(st.row);
      gsum_upd  = gsum_r + mrs_pkg::GSUM_W'(st.gray);
      if (st.gray < min_r) begin
        min_upd = st.gray;
      end
      if (st.gray > max_r) begin
        max_upd = st.gray;
      end
      if ((cnt_new > best_cnt_r) || ((cnt_new == best_cnt_r) && (bin < best_bin_r))) begin
        best_cnt_upd = cnt_new;
        best_bin_upd = bin;
      end
    end
  end

  // commit, or clear after the last pixel of a frame
  always_comb begin
    count_nxt    = count_r;
    xsum_nxt     = xsum_r;
    ysum_nxt     = ysum_r;
    perim_nxt    = perim_r;
    gsum_nxt     = gsum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    best_bin_nxt = best_bin_r;
    best_cnt_nxt = best_cnt_r;
    hvalid_nxt   = hvalid_r;
    if (done) begin
      if (st.frame_end) begin
        count_nxt    = '0;
        xsum_nxt     = '0;
        ysum_nxt     = '0;
        perim_nxt    = '0;
        gsum_nxt     = '0;
        min_nxt      = '1;
        max_nxt      = '0;
        best_bin_nxt = '0;
        best_cnt_nxt = '0;
        hvalid_nxt   = '0;
      end else begin
        count_nxt    = count_upd;
        xsum_nxt     = xsum_upd;
        ysum_nxt     = ysum_upd;
        perim_nxt    = perim_upd;
        gsum_nxt     = gsum_upd;
        min_nxt      = min_upd;
        max_nxt      = max_upd;
        best_bin_nxt = best_bin_upd;
        best_cnt_nxt = best_cnt_upd;
        if (st.mask) begin
          hvalid_nxt[bin] = 1'b1;
        end
      end
    end
  end

  // forward register follows each accepted read
  always_comb begin
    hfwd_v_nxt   = hfwd_v_r;
    hfwd_bin_nxt = hfwd_bin_r;
    hfwd_cnt_nxt = hfwd_cnt_r;
    if (rd_en) begin
      hfwd_v_nxt   = done && st.mask && !st.frame_end;
      hfwd_bin_nxt = bin;
      hfwd_cnt_nxt = cnt_new;
    end
  end

  // result register
  assign empty = (count_upd == '0);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_empty_nxt = out_empty_r;
    res_nxt       = res_r;
    if (done && st.frame_end) begin
      out_valid_nxt      = 1'b1;
      out_empty_nxt      = empty;
      res_nxt.area       = count_upd;
      res_nxt.column_sum = xsum_upd;
      res_nxt.row_sum    = ysum_upd;
      res_nxt.edge_count = perim_upd;
      res_nxt.gray_total = gsum_upd;
      res_nxt.gray_min   = empty ? '0 : min_upd;
      res_nxt.gray_max   = empty ? '0 : max_upd;
      res_nxt.modal_gray = empty ? '0 : mrs_pkg::GRAY_W'(best_bin_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      perim_r     <= '0;
      gsum_r      <= '0;
      min_r       <= '1;
      max_r       <= '0;
      best_bin_r  <= '0;
      best_cnt_r  <= '0;
      hvalid_r    <= '0;
      hfwd_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      xsum_r      <= xsum_nxt;
      ysum_r      <= ysum_nxt;
      perim_r     <= perim_nxt;
      gsum_r      <= gsum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      best_bin_r  <= best_bin_nxt;
      best_cnt_r  <= best_cnt_nxt;
      hvalid_r    <= hvalid_nxt;
      hfwd_v_r    <= hfwd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hfwd_bin_r  <= hfwd_bin_nxt;
    hfwd_cnt_r  <= hfwd_cnt_nxt;
    out_empty_r <= out_empty_nxt;
    res_r       <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mrs_pkg::OUT_TDATA_W'(res_r);
  assign out_tuser  = out_empty_r;

  `MRS_ASSERT_NXT(a_frame_end_clears, clk, rst_n, done && st.frame_end,
    (count_r == '0) && out_valid_r && (hvalid_r == '0))
  `MRS_ASSERT_IMP(a_empty_result_zero, clk, rst_n, out_valid_r && out_empty_r,
    (res_r.area == '0) && (res_r.gray_min == '0) && (res_r.gray_max == '0) && (res_r.modal_gray == '0))

endmodule

[rtl/core/masked_region_statistics.sv]
// out_tvalid rises once the frame's last pixel has passed the stage and result registers
// throughput: one pixel per cycle, set by the read-modify-write of the histogram and
// row-above memories with write-to-read forwarding; stalls while a frame end waits on an
// untaken result; reset: synchronous active-low rst_n; afterwards a clearing pass zeroes
// all 4096 row-above entries with in_tready low, configuration writes are taken throughout
// top level: depends on mrs_pkg, mrs_cfg, mrs_scan, mrs_accum and assert_macros.svh
`include "assert_macros.svh"
module masked_region_statistics (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] gray
  input  logic                            in_tuser,   // [0] in_object
  // frame result
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [24:0] area, [59:25] column_sum, [94:60] row_sum, [120:95] edge_count,
  // [152:121] gray_total, [160:153] gray_min, [168:161] gray_max,
  // [176:169] modal_gray, [183:177] zero
  output logic [mrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // [0] region_empty
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mrs_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [mrs_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [mrs_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  mrs_pkg::frame_size_t size;
  mrs_pkg::stage_t      st;
  logic                 accept;
  logic                 adv;
  logic [1:0]           edge_inc;

  // configuration registers
  mrs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .size        (size)
  );

  // raster position and perimeter
  mrs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .gray      (in_tdata[mrs_pkg::GRAY_W-1:0]),
    .mask      (in_tuser),
    .size      (size),
    .adv       (adv),
    .accept    (accept),
    .st        (st),
    .edge_inc  (edge_inc)
  );

  // statistics, histogram and result
  mrs_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_gray    (in_tdata[mrs_pkg::GRAY_W-1:0]),
    .st         (st),
    .edge_inc   (edge_inc),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `MRS_ASSERT_IMP(a_stall_needs_full_output, clk, rst_n, st.valid && !adv,
    st.frame_end && out_tvalid && !in_tready)

endmodule

[bench/masked_region_statistics_tb.sv]
// self-checking testbench for masked_region_statistics: directed and random pixel frames,
// each frame result compared field by field against an in-bench model of the statistics
// depends on mrs_pkg and the rtl of the block
module masked_region_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrs_pkg::*;

  localparam int RANDOM_PIXELS = 1530;
  localparam int LONG_RUN      = 256;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              masked;
  } pixel_t;

  typedef struct packed {
    result_t stats;
    logic    region_empty;
  } frame_result_t;

  // block ports
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // stimulus and scoreboard
  pixel_t        pending_pixels[$];
  frame_result_t expected_frames[$];
  pixel_t        offered_pixel;
  int unsigned   pixels_queued   = 0;
  int unsigned   pixels_taken    = 0;
  int unsigned   frames_checked  = 0;
  int unsigned   empty_frames    = 0;
  int unsigned   mismatch_count  = 0;
  int unsigned   cycle_count     = 0;
  int unsigned   src_gap_max     = 0;
  int unsigned   sink_stall_max  = 0;
  int unsigned   hold_asked      = 0;
  int unsigned   hold_served     = 0;
  int unsigned   gap_left        = 0;
  int unsigned   stall_left      = 0;
  int unsigned   hold_left       = 0;

  // model of the frame statistics
  logic [REG_W-1:0]  width_reg;
  logic [REG_W-1:0]  height_reg;
  bit                above_mask[MAX_WIDTH];
  bit                left_bit;
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [AREA_W-1:0] area_acc;
  logic [35:0]       col_acc;
  logic [35:0]       row_acc;
  logic [EDGE_W-1:0] edge_acc;
  logic [GSUM_W-1:0] gray_acc;
  logic [GRAY_W-1:0] min_gray;
  logic [GRAY_W-1:0] max_gray;
  logic [AREA_W-1:0] hist[GRAY_LEVELS];
  int unsigned       best_bin;
  logic [AREA_W-1:0] best_count;

  masked_region_statistics i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // register value as the datapath sees it: zero acts as one, large values saturate
  function automatic int unsigned eff_size(input logic [REG_W-1:0] v, input int unsigned limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void clear_frame_stats();
    col_pos    = 0;
    row_pos    = 0;
    left_bit   = 1'b0;
    area_acc   = '0;
    col_acc    = '0;
    row_acc    = '0;
    edge_acc   = '0;
    gray_acc   = '0;
    min_gray   = '1;
    max_gray   = '0;
    best_bin   = 0;
    best_count = '0;
    foreach (hist[i]) hist[i] = '0;
  endfunction

  // advance the frame statistics by one pixel, queue a result at frame end
  function automatic void update_region_stats(input pixel_t p);
    int unsigned   w, h, c, r, bin;
    bit            row_end, frame_end, no_object;
    frame_result_t res;
    w         = eff_size(width_reg, MAX_WIDTH);
    h         = eff_size(height_reg, MAX_HEIGHT);
    c         = col_pos % MAX_WIDTH;
    r         = row_pos;
    row_end   = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);

    // perimeter: left and upper neighbors inside the image
    if (c > 0 && left_bit != p.masked) edge_acc = edge_acc + 1'b1;
    if (r > 0 && above_mask[c] != p.masked) edge_acc = edge_acc + 1'b1;
    above_mask[c] = p.masked;
    left_bit      = p.masked;

    if (p.masked) begin
      bin      = (p.gray < GRAY_LEVELS) ? p.gray : GRAY_LEVELS - 1;
      area_acc = area_acc + 1'b1;
      col_acc  = col_acc + 36'(c);
      row_acc  = row_acc + 36'(r);
      gray_acc = gray_acc + GSUM_W'(p.gray);
      if (p.gray < min_gray) min_gray = p.gray;
      if (p.gray > max_gray) max_gray = p.gray;
      hist[bin] = hist[bin] + 1'b1;
      if (hist[bin] > best_count || (hist[bin] == best_count && bin < best_bin)) begin
        best_count = hist[bin];
        best_bin   = bin;
      end
    end

    if (row_end) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end

    if (frame_end) begin
      no_object              = (area_acc == '0);
      res.stats.area         = area_acc;
      res.stats.column_sum   = col_acc[SUM_W-1:0];
      res.stats.row_sum      = row_acc[SUM_W-1:0];
      res.stats.edge_count   = edge_acc;
      res.stats.gray_total   = gray_acc;
      res.stats.gray_min     = no_object ? '0 : min_gray;
      res.stats.gray_max     = no_object ? '0 : max_gray;
      res.stats.modal_gray   = no_object ? '0 : GRAY_W'(best_bin);
      res.region_empty       = no_object;
      expected_frames.insert(expected_frames.size(), res);
      clear_frame_stats();
    end
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic check_frame();
    result_t       got;
    frame_result_t want;
    got = result_t'(out_tdata[RES_W-1:0]);
    if (expected_frames.size() == 0) begin
      mismatch_count++;
      $display("%0t: frame result arrived with none expected, area %0d", $time, got.area);
      return;
    end
    want = expected_frames.pop_front();
    frames_checked++;
    if (want.region_empty) empty_frames++;
    check_field("area", want.stats.area, got.area);
    check_field("column_sum", want.stats.column_sum, got.column_sum);
    check_field("row_sum", want.stats.row_sum, got.row_sum);
    check_field("edge_count", want.stats.edge_count, got.edge_count);
    check_field("gray_total", want.stats.gray_total, got.gray_total);
    check_field("gray_min", want.stats.gray_min, got.gray_min);
    check_field("gray_max", want.stats.gray_max, got.gray_max);
    check_field("modal_gray", want.stats.modal_gray, got.modal_gray);
    check_field("region_empty", want.region_empty, out_tuser);
  endtask

  // pixel driver: one transaction per queued pixel, random gap after each
  always @(posedge clk) begin : pixel_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        update_region_stats(offered_pixel);
        pixels_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        offered_pixel = pending_pixels.pop_front();
        in_tdata  <= offered_pixel.gray;
        in_tuser  <= offered_pixel.masked;
        in_tvalid <= 1'b1;
        gap_left  = $urandom_range(0, src_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor: random stall per result, long hold-off on request
  always @(posedge clk) begin : result_monitor
    logic ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_frame();
        stall_left = $urandom_range(0, sink_stall_max);
      end
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // register write, then read back the same register
  task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] value);
    logic [CFG_DW-1:0] readback;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= ($urandom << REG_W) | CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field(idx == REG_IMAGE_WIDTH ? "image_width readback" : "image_height readback",
                CFG_DW'(value), readback);
  endtask

  // sender pauses until every queued pixel is taken and every result is in
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_pixel(input logic [GRAY_W-1:0] gray, input logic masked);
    pending_pixels.insert(pending_pixels.size(), pixel_t'{gray: gray, masked: masked});
    pixels_queued++;
  endtask

  task automatic queue_pixels(input int unsigned count, input int unsigned density);
    logic [GRAY_W-1:0] g;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       g = '0;
        1:       g = '1;
        default: g = GRAY_W'($urandom);
      endcase
      add_pixel(g, $urandom_range(0, 99) < density);
    end
  endtask

  function automatic logic [REG_W-1:0] rand_size(input int unsigned top);
    if ($urandom_range(0, 15) == 0) return '0;
    return REG_W'($urandom_range(1, top));
  endfunction

  initial begin : stimulus
    int unsigned phase, frames, density, frame_px, directed_px;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    foreach (above_mask[i]) above_mask[i] = 1'b0;
    clear_frame_stats();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of gray, tied modal bins, empty frame
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    add_pixel(8'd200, 1'b1);
    add_pixel(8'd7,   1'b1);
    add_pixel(8'd0,   1'b0);
    add_pixel(8'd200, 1'b1);
    add_pixel(8'd7,   1'b1);
    add_pixel(8'd255, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    add_pixel(8'd0,   1'b1);
    add_pixel(8'd255, 1'b1);
    add_pixel(8'd255, 1'b1);
    add_pixel(8'd0,   1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    add_pixel(8'd128, 1'b0);

    // oversized frame cut short by shrinking width, then height, mid-frame
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd8191);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    add_pixel(8'd90, 1'b1);
    add_pixel(8'd91, 1'b0);
    add_pixel(8'd92, 1'b1);
    add_pixel(8'd93, 1'b1);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    add_pixel(8'd94, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    add_pixel(8'd95, 1'b1);
    directed_px = pixels_queued;

    // random phases, each opened by a pause until the block is idle
    phase = 0;
    while (pixels_queued < directed_px + RANDOM_PIXELS) begin
      phase++;
      src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 6;
      sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      wait_idle();
      case ($urandom_range(0, 4))
        0:       density = 0;
        1:       density = 100;
        2:       density = 20;
        3:       density = 80;
        default: density = 50;
      endcase
      if (phase == 4) begin
        // one result per pixel while the output is held off: the block backs up
        src_gap_max = 0;
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        hold_asked++;
        queue_pixels(40, 50);
      end else if (phase == 9) begin
        // long partial row in a full-width frame, ended by the next resize
        write_reg(REG_IMAGE_WIDTH, 13'd4096);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        queue_pixels(LONG_RUN, 50);
      end else if (phase == 15) begin
        // long partial column in a full-height frame, ended by the next resize
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        queue_pixels(LONG_RUN, 50);
      end else begin
        // a size left large by a long run is always rewritten
        if ($urandom_range(0, 2) != 0 || eff_size(width_reg, MAX_WIDTH) > 12)
          write_reg(REG_IMAGE_WIDTH, rand_size(12));
        if ($urandom_range(0, 2) != 0 || eff_size(height_reg, MAX_HEIGHT) > 6)
          write_reg(REG_IMAGE_HEIGHT, rand_size(6));
        frame_px = eff_size(width_reg, MAX_WIDTH) * eff_size(height_reg, MAX_HEIGHT);
        frames   = $urandom_range(1, 6);
        queue_pixels(frames * frame_px, density);
        // sometimes leave a frame half done so the next resize lands mid-frame
        if ($urandom_range(0, 4) == 0) queue_pixels($urandom_range(1, frame_px), density);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d pixels and %0d frame results, %0d of them empty",
             pixels_taken, frames_checked, empty_frames);
    $display("small and 1x1 frames, long runs in 4096-sized frames, resizes, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
